>>> src/pfbd_pkg.sv
// ----------------------------------------------------------------------------
// Potentiometer filter and button debounce package
// Transaction types and fixed constants shared by the block's modules.
// ----------------------------------------------------------------------------
package pfbd_pkg;

  localparam int unsigned AdcW = 10;
  localparam int unsigned PosW = 8;
  localparam int unsigned CntW = 2;

  localparam int unsigned FilterRound = 4;
  localparam int unsigned FilterShift = 3;

  localparam logic [CntW-1:0] DebounceLast = 2'd3;
  localparam logic [PosW-1:0] SpanReset    = 8'd14;

  typedef struct packed {
    logic [AdcW-1:0] adc_sample;
    logic            button_level;
  } in_t;

  typedef struct packed {
    logic            position_changed;
    logic [PosW-1:0] position;
    logic            fire;
  } out_t;

endpackage

>>> src/pot_filter_and_button_debounce.sv
// ----------------------------------------------------------------------------
// Potentiometer filter and button debounce
// Low-pass filters a potentiometer sample into a scaled position and
// debounces a push button, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle unless stalled and
// returns exactly one result transaction for each, in order. An accepted
// transaction lands in an input register; as it advances, the filter update,
// the position multiply and the debounce step run in one pass and the result
// is captured in the output register. The combinational path from
// the input register through the span multiplier sets the clock rate. When
// the result side stalls, one transaction waits in the input register and
// in_ready_o falls only when both registers are full. position_span is
// written through cfg_we_i and resets to 14; write it only while idle.
module pot_filter_and_button_debounce #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pfbd_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pfbd_pkg::out_t            out_data_o,
  input  logic                      cfg_we_i,
  input  logic [pfbd_pkg::PosW-1:0] cfg_wdata_i
);

  logic                      in_valid_q;
  pfbd_pkg::in_t             in_data_q;
  logic                      out_valid_q;
  pfbd_pkg::out_t            out_data_q;
  logic [pfbd_pkg::PosW-1:0] span_q;
  logic                      advance;
  pfbd_pkg::out_t            result;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  pfbd_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .item_i  (in_data_q),
    .span_i  (span_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= pfbd_pkg::SpanReset;
    end else if (cfg_we_i) begin
      span_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while the result register is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result transaction without a registered input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q && !out_valid_q |=> !out_valid_o)
    else $error("result transaction invented from an empty pipeline");
`endif

endmodule

>>> src/pfbd_core.sv
// ----------------------------------------------------------------------------
// Filter and debounce datapath
// Holds the filter, position and debounce state and computes one result from
// the registered input transaction; the state advances when en_i is high.
// ----------------------------------------------------------------------------
module pfbd_core #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  pfbd_pkg::in_t           item_i,
  input  logic [pfbd_pkg::PosW-1:0] span_i,
  output pfbd_pkg::out_t          result_o
);

  localparam int unsigned DiffW = SAMPLE_BITS + 2;
  localparam int unsigned ProdW = SAMPLE_BITS + 1 + pfbd_pkg::PosW;

  logic [SAMPLE_BITS-1:0]     level_q, level_d;
  logic [pfbd_pkg::PosW-1:0]  last_pos_q;
  logic                       stable_q, stable_d;
  logic [pfbd_pkg::CntW-1:0]  cnt_q, cnt_d;

  logic [pfbd_pkg::AdcW+SAMPLE_BITS-1:0] sample_wide;
  logic [SAMPLE_BITS-1:0]     sample;
  logic signed [DiffW-1:0]    diff;
  logic signed [DiffW-1:0]    step;
  logic signed [DiffW-1:0]    sum;
  logic [SAMPLE_BITS:0]       inverted;
  logic [ProdW-1:0]           product;
  logic [pfbd_pkg::PosW-1:0]  pos;
  logic                       fire;

  always_comb begin
    sample_wide = {{SAMPLE_BITS{1'b0}}, item_i.adc_sample};
    sample      = sample_wide[SAMPLE_BITS-1:0];
    diff = $signed({2'b00, sample}) - $signed({2'b00, level_q})
         + $signed(DiffW'(pfbd_pkg::FilterRound));
    step = diff >>> pfbd_pkg::FilterShift;
    sum  = $signed({2'b00, level_q}) + step;
    if (sum < 0) begin
      level_d = '0;
    end else begin
      level_d = sum[SAMPLE_BITS-1:0];
    end
    inverted = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, level_d};
    product  = ProdW'(inverted) * ProdW'(span_i);
    pos      = product[SAMPLE_BITS +: pfbd_pkg::PosW];
  end

  always_comb begin
    stable_d = stable_q;
    cnt_d    = '0;
    fire     = 1'b0;
    if (item_i.button_level != stable_q) begin
      if (cnt_q >= pfbd_pkg::DebounceLast) begin
        stable_d = item_i.button_level;
        fire     = !item_i.button_level;
      end else begin
        cnt_d = cnt_q + pfbd_pkg::CntW'(1);
      end
    end
  end

  always_comb begin
    result_o.position_changed = (pos != last_pos_q);
    result_o.position         = pos;
    result_o.fire             = fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      last_pos_q <= '0;
      stable_q   <= 1'b0;
      cnt_q      <= '0;
    end else if (en_i) begin
      level_q    <= level_d;
      last_pos_q <= pos;
      stable_q   <= stable_d;
      cnt_q      <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> result_o.position <= span_i)
    else $error("position exceeds the configured span");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && result_o.fire |-> !item_i.button_level && stable_q)
    else $error("fire raised without a press being accepted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.button_level == stable_q) |=> cnt_q == '0)
    else $error("debounce count not cleared on a matching sample");
`endif

endmodule
